FILE: hw/rtl/ctt_pkg.sv
// shared types, codes and helpers for the config text tokenizer
// no dependencies
package ctt_pkg;

    localparam int POS_BITS = 16;

    typedef logic [POS_BITS-1:0] pos_t;

    typedef enum logic [4:0] {
        K_ID_CHAR  = 5'd0,
        K_STR_CHAR = 5'd1,
        K_IDENT    = 5'd2,
        K_TASK     = 5'd3,
        K_TRUE     = 5'd4,
        K_FALSE    = 5'd5,
        K_DEPENDS  = 5'd6,
        K_INTEGER  = 5'd7,
        K_STRING   = 5'd8,
        K_LBRACE   = 5'd9,
        K_RBRACE   = 5'd10,
        K_EQUALS   = 5'd11,
        K_SEMI     = 5'd12,
        K_COMMA    = 5'd13,
        K_UNKNOWN  = 5'd14,
        K_END      = 5'd15,
        K_ERROR    = 5'd16
    } kind_t;

    typedef enum logic [1:0] {
        E_NONE      = 2'd0,
        E_UNTERM_STR = 2'd1,
        E_UNTERM_CMT = 2'd2,
        E_BAD_ESC    = 2'd3
    } err_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [7:0]  char_out;
        logic [31:0] number;
        logic [15:0] start_pos;
        logic [15:0] end_pos;
        logic [1:0]  error_code;
        logic        last;
    } res_t;

    localparam int MAX_RES = 3;

    // low 16 bits of a position, zero extended if narrower
    function automatic logic [15:0] pos16(input pos_t p);
        logic [31:0] w;
        begin
            w = 32'(p);
            return w[15:0];
        end
    endfunction

    function automatic res_t mk_res(input kind_t k, input logic [7:0] c,
                                    input logic [31:0] num, input pos_t s,
                                    input pos_t e, input err_t err);
        res_t r;
        begin
            r.kind       = k;
            r.char_out   = c;
            r.number     = num;
            r.start_pos  = pos16(s);
            r.end_pos    = pos16(e);
            r.error_code = err;
            r.last       = 1'b0;
            return r;
        end
    endfunction

endpackage

FILE: hw/rtl/ctt_stream_if.sv
// valid/ready channel interfaces for the tokenizer input and result streams
// depends on nothing
interface ctt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_text;

    modport source (output valid, output ch, output end_of_text, input ready);
    modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

interface ctt_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  kind;
    logic [7:0]  char_out;
    logic signed [31:0] number;
    logic [15:0] start_pos;
    logic [15:0] end_pos;
    logic [1:0]  error_code;
    logic        last;

    modport source (output valid, output kind, output char_out, output number,
                    output start_pos, output end_pos, output error_code,
                    output last, input ready);
    modport sink   (input valid, input kind, input char_out, input number,
                    input start_pos, input end_pos, input error_code,
                    input last, output ready);
endinterface

FILE: hw/rtl/ctt_lexer.sv
// lexer state registers and the per-byte step producing up to three results
// depends on ctt_pkg
module ctt_lexer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic [7:0]      ch,
    input  logic            end_of_text,
    output ctt_pkg::res_t   res [ctt_pkg::MAX_RES],
    output logic [1:0]      res_count
);

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_SLASH, M_LINE,
        M_BLOCK, M_BSTAR, M_STRING, M_ESC
    } mode_t;

    mode_t              mode_reg, mode_next;
    ctt_pkg::pos_t      pos_reg, pos_next;
    ctt_pkg::pos_t      tstart_reg, tstart_next;
    logic [31:0]        acc_reg, acc_next;
    logic [55:0]        kw_reg, kw_next;
    logic [3:0]         kwlen_reg, kwlen_next;

    function automatic logic is_letter(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) || c == 8'h5F;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    always_comb
    begin
        ctt_pkg::pos_t p;
        ctt_pkg::pos_t nx;
        logic          start;
        logic [1:0]    n;
        ctt_pkg::kind_t ik;
        logic [7:0]    d;
        logic          esc_ok;
        p           = pos_reg;
        nx          = pos_reg + 1'b1;
        start       = 1'b0;
        n           = 2'd0;
        ik          = ctt_pkg::K_IDENT;
        d           = 8'd0;
        esc_ok      = 1'b1;
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        tstart_next = tstart_reg;
        acc_next    = acc_reg;
        kw_next     = kw_reg;
        kwlen_next  = kwlen_reg;
        for (int i = 0; i < ctt_pkg::MAX_RES; i++)
        begin
            res[i] = '0;
        end

        // keyword match for a closing identifier
        if (kwlen_reg == 4'd4 && kw_reg == 56'h7461736B)
            ik = ctt_pkg::K_TASK;
        else if (kwlen_reg == 4'd4 && kw_reg == 56'h74727565)
            ik = ctt_pkg::K_TRUE;
        else if (kwlen_reg == 4'd5 && kw_reg == 56'h66616C7365)
            ik = ctt_pkg::K_FALSE;
        else if (kwlen_reg == 4'd7 && kw_reg == 56'h646570656E6473)
            ik = ctt_pkg::K_DEPENDS;

        case (ch)
            8'h61: d = 8'd7;
            8'h62: d = 8'd8;
            8'h66: d = 8'd12;
            8'h6E: d = 8'd10;
            8'h72: d = 8'd13;
            8'h74: d = 8'd9;
            8'h76: d = 8'd11;
            8'h5C: d = 8'h5C;
            8'h27: d = 8'h27;
            8'h22: d = 8'h22;
            default: esc_ok = 1'b0;
        endcase

        if (end_of_text)
        begin
            case (mode_reg)
                M_IDENT:
                begin
                    res[n] = ctt_pkg::mk_res(ik, 8'd0, 32'd0, tstart_reg, p,
                                             ctt_pkg::E_NONE);
                    n = n + 2'd1;
                end
                M_NUMBER:
                begin
                    res[n] = ctt_pkg::mk_res(ctt_pkg::K_INTEGER, 8'd0, acc_reg,
                                             tstart_reg, p, ctt_pkg::E_NONE);
                    n = n + 2'd1;
                end
                M_SLASH:
                begin
                    res[n] = ctt_pkg::mk_res(ctt_pkg::K_UNKNOWN, 8'd0, 32'd0,
                                             tstart_reg, p, ctt_pkg::E_NONE);
                    n = n + 2'd1;
                end
                M_STRING, M_ESC:
                begin
                    res[n] = ctt_pkg::mk_res(ctt_pkg::K_ERROR, 8'd0, 32'd0,
                                             tstart_reg, p, ctt_pkg::E_UNTERM_STR);
                    n = n + 2'd1;
                    res[n] = ctt_pkg::mk_res(ctt_pkg::K_STRING, 8'd0, 32'd0,
                                             tstart_reg, p, ctt_pkg::E_NONE);
                    n = n + 2'd1;
                end
                M_BLOCK, M_BSTAR:
                begin
                    res[n] = ctt_pkg::mk_res(ctt_pkg::K_ERROR, 8'd0, 32'd0,
                                             p, p, ctt_pkg::E_UNTERM_CMT);
                    n = n + 2'd1;
                end
                default: ;
            endcase
            res[n] = ctt_pkg::mk_res(ctt_pkg::K_END, 8'd0, 32'd0, p, p,
                                     ctt_pkg::E_NONE);
            n = n + 2'd1;
            mode_next   = M_IDLE;
            pos_next    = '0;
            tstart_next = '0;
            acc_next    = '0;
            kw_next     = '0;
            kwlen_next  = '0;
        end
        else
        begin
            pos_next = nx;
            case (mode_reg)
                M_IDENT:
                begin
                    if (is_letter(ch) || is_digit(ch))
                    begin
                        if (kwlen_reg < 4'd7)
                        begin
                            kw_next    = {kw_reg[47:0], ch};
                            kwlen_next = kwlen_reg + 4'd1;
                        end
                        else
                        begin
                            kwlen_next = 4'd8;
                        end
                        res[n] = ctt_pkg::mk_res(ctt_pkg::K_ID_CHAR, ch, 32'd0,
                                                 tstart_reg, nx, ctt_pkg::E_NONE);
                        n = n + 2'd1;
                    end
                    else
                    begin
                        res[n] = ctt_pkg::mk_res(ik, 8'd0, 32'd0, tstart_reg, p,
                                                 ctt_pkg::E_NONE);
                        n = n + 2'd1;
                        start = 1'b1;
                    end
                end
                M_NUMBER:
                begin
                    if (is_digit(ch))
                    begin
                        acc_next = (acc_reg << 3) + (acc_reg << 1)
                                 + 32'(ch - 8'h30);
                    end
                    else
                    begin
                        res[n] = ctt_pkg::mk_res(ctt_pkg::K_INTEGER, 8'd0, acc_reg,
                                                 tstart_reg, p, ctt_pkg::E_NONE);
                        n = n + 2'd1;
                        start = 1'b1;
                    end
                end
                M_SLASH:
                begin
                    if (ch == 8'h2F)
                        mode_next = M_LINE;
                    else if (ch == 8'h2A)
                        mode_next = M_BLOCK;
                    else
                    begin
                        res[n] = ctt_pkg::mk_res(ctt_pkg::K_UNKNOWN, 8'd0, 32'd0,
                                                 tstart_reg, p, ctt_pkg::E_NONE);
                        n = n + 2'd1;
                        start = 1'b1;
                    end
                end
                M_LINE:
                begin
                    if (ch == 8'h0A)
                        mode_next = M_IDLE;
                end
                M_BLOCK:
                begin
                    if (ch == 8'h2A)
                        mode_next = M_BSTAR;
                end
                M_BSTAR:
                begin
                    if (ch == 8'h2F)
                        mode_next = M_IDLE;
                    else if (ch != 8'h2A)
                        mode_next = M_BLOCK;
                end
                M_STRING:
                begin
                    if (ch == 8'h0A)
                    begin
                        res[n] = ctt_pkg::mk_res(ctt_pkg::K_ERROR, 8'd0, 32'd0,
                                                 tstart_reg, p,
                                                 ctt_pkg::E_UNTERM_STR);
                        n = n + 2'd1;
                        res[n] = ctt_pkg::mk_res(ctt_pkg::K_STRING, 8'd0, 32'd0,
                                                 tstart_reg, p, ctt_pkg::E_NONE);
                        n = n + 2'd1;
                        start = 1'b1;
                    end
                    else if (ch == 8'h22)
                    begin
                        res[n] = ctt_pkg::mk_res(ctt_pkg::K_STRING, 8'd0, 32'd0,
                                                 tstart_reg, nx, ctt_pkg::E_NONE);
                        n = n + 2'd1;
                        mode_next = M_IDLE;
                    end
                    else if (ch == 8'h5C)
                        mode_next = M_ESC;
                    else
                    begin
                        res[n] = ctt_pkg::mk_res(ctt_pkg::K_STR_CHAR, ch, 32'd0,
                                                 tstart_reg, nx, ctt_pkg::E_NONE);
                        n = n + 2'd1;
                    end
                end
                M_ESC:
                begin
                    mode_next = M_STRING;
                    if (esc_ok)
                    begin
                        res[n] = ctt_pkg::mk_res(ctt_pkg::K_STR_CHAR, d, 32'd0,
                                                 tstart_reg, nx, ctt_pkg::E_NONE);
                        n = n + 2'd1;
                    end
                    else
                    begin
                        // error spans the backslash and the character
                        res[n] = ctt_pkg::mk_res(ctt_pkg::K_ERROR, 8'd0, 32'd0,
                                                 p - 1'b1, nx, ctt_pkg::E_BAD_ESC);
                        n = n + 2'd1;
                        res[n] = ctt_pkg::mk_res(ctt_pkg::K_STR_CHAR, 8'h5C, 32'd0,
                                                 tstart_reg, nx, ctt_pkg::E_NONE);
                        n = n + 2'd1;
                        res[n] = ctt_pkg::mk_res(ctt_pkg::K_STR_CHAR, ch, 32'd0,
                                                 tstart_reg, nx, ctt_pkg::E_NONE);
                        n = n + 2'd1;
                    end
                end
                default: start = 1'b1;
            endcase

            if (start)
            begin
                mode_next = M_IDLE;
                if (ch > 8'd32)
                begin
                    if (is_letter(ch))
                    begin
                        mode_next   = M_IDENT;
                        tstart_next = p;
                        kw_next     = 56'(ch);
                        kwlen_next  = 4'd1;
                        res[n] = ctt_pkg::mk_res(ctt_pkg::K_ID_CHAR, ch, 32'd0,
                                                 p, nx, ctt_pkg::E_NONE);
                        n = n + 2'd1;
                    end
                    else if (is_digit(ch))
                    begin
                        mode_next   = M_NUMBER;
                        tstart_next = p;
                        acc_next    = 32'(ch - 8'h30);
                    end
                    else if (ch == 8'h2F)
                    begin
                        mode_next   = M_SLASH;
                        tstart_next = p;
                    end
                    else if (ch == 8'h22)
                    begin
                        mode_next   = M_STRING;
                        tstart_next = p;
                    end
                    else
                    begin
                        case (ch)
                            8'h7B: ik = ctt_pkg::K_LBRACE;
                            8'h7D: ik = ctt_pkg::K_RBRACE;
                            8'h3D: ik = ctt_pkg::K_EQUALS;
                            8'h3B: ik = ctt_pkg::K_SEMI;
                            8'h2C: ik = ctt_pkg::K_COMMA;
                            default: ik = ctt_pkg::K_UNKNOWN;
                        endcase
                        res[n] = ctt_pkg::mk_res(ik, 8'd0, 32'd0, p, nx,
                                                 ctt_pkg::E_NONE);
                        n = n + 2'd1;
                    end
                end
            end
        end

        if (n != 2'd0)
            res[n - 2'd1].last = 1'b1;
        res_count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            tstart_reg <= '0;
            acc_reg    <= '0;
            kw_reg     <= '0;
            kwlen_reg  <= '0;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            tstart_reg <= tstart_next;
            acc_reg    <= acc_next;
            kw_reg     <= kw_next;
            kwlen_reg  <= kwlen_next;
        end
    end

endmodule

FILE: hw/rtl/ctt_res_queue.sv
// four-entry result queue taking up to three results per cycle on push, one out while out_ready
// depends on ctt_pkg
module ctt_res_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ctt_pkg::res_t  push_res [ctt_pkg::MAX_RES],
    input  logic [1:0]     push_count,
    output logic           room,
    output logic           out_valid,
    input  logic           out_ready,
    output ctt_pkg::res_t  out_res
);

    ctt_pkg::res_t mem [4];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    logic [2:0] after_pop;
    logic [1:0] n_in;

    assign out_valid = cnt_reg != 3'd0;
    assign out_res   = mem[rd_reg];
    assign pop       = out_valid && out_ready;
    assign after_pop = cnt_reg - {2'b00, pop};
    // space for a worst-case item of three results
    assign room      = after_pop <= 3'd1;
    assign n_in      = push ? push_count : 2'd0;
    assign wr_next   = wr_reg + n_in;
    assign rd_next   = rd_reg + {1'b0, pop};
    assign cnt_next  = after_pop + {1'b0, n_in};

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ctt_pkg::MAX_RES; i++)
        begin
            if (2'(i) < n_in)
                mem[wr_reg + 2'(i)] <= push_res[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: hw/rtl/config_text_tokenizer_core.sv
// top level of the config text tokenizer: lexer step plus result queue
// depends on ctt_pkg, ctt_stream_if, ctt_lexer, ctt_res_queue
//
// usage
//   in_tok carries one text byte per transaction (ch), or an end-of-text
//   marker (end_of_text = 1, ch ignored). out_tok carries token events:
//   identifier/string characters, closing token events, errors and the end
//   event. each input transaction yields zero to three result transactions,
//   the final one of them flagged by last.
//   the results of a byte are computed in the cycle it is accepted and written
//   to the result queue, which sends them on out_tok one per cycle, in order.
//   throughput: one byte per cycle while bytes yield at most one result each
//   and out_tok.ready is high; a byte yielding more holds back later bytes, as
//   the four-entry result queue takes a byte only when at most one result is
//   left after this cycle's output transaction.
//   reset: rst_n (async, active low) puts the lexer idle at offset zero and
//   empties the queue. end of text also returns the lexer to that state.
//   stall: while out_tok.ready is low, queued results hold and in_tok.ready
//   drops once the queue cannot take another worst-case byte.
module config_text_tokenizer_core (
    input  logic       clk,
    input  logic       rst_n,
    ctt_in_if.sink     in_tok,
    ctt_out_if.source  out_tok
);

    ctt_pkg::res_t step_res [ctt_pkg::MAX_RES];
    ctt_pkg::res_t head;
    logic [1:0]    step_count;
    logic          room;
    logic          fire;

    // input ready depends only on queue occupancy and the output handshake
    assign in_tok.ready = room;
    assign fire         = in_tok.valid && room;

    ctt_lexer u_lexer (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .ch          (in_tok.ch),
        .end_of_text (in_tok.end_of_text),
        .res         (step_res),
        .res_count   (step_count)
    );

    ctt_res_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fire),
        .push_res   (step_res),
        .push_count (step_count),
        .room       (room),
        .out_valid  (out_tok.valid),
        .out_ready  (out_tok.ready),
        .out_res    (head)
    );

    assign out_tok.kind       = head.kind;
    assign out_tok.char_out   = head.char_out;
    assign out_tok.number     = head.number;
    assign out_tok.start_pos  = head.start_pos;
    assign out_tok.end_pos    = head.end_pos;
    assign out_tok.error_code = head.error_code;
    assign out_tok.last       = head.last;

endmodule

FILE: hw/rtl/ctt_checker.sv
// port-level checks on the tokenizer result stream, bound to the top level
// depends on ctt_pkg and config_text_tokenizer_core
module ctt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [4:0]  kind,
    input logic [15:0] start_pos,
    input logic [15:0] end_pos,
    input logic [1:0]  error_code,
    input logic        last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind))
        else $error("result changed while stalled");

    a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == ctt_pkg::K_ERROR |-> error_code != ctt_pkg::E_NONE)
        else $error("error event without code");

    a_err_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != ctt_pkg::K_ERROR |-> error_code == ctt_pkg::E_NONE)
        else $error("error code on non-error event");

    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == ctt_pkg::K_END |-> last && start_pos == end_pos)
        else $error("malformed end event");

endmodule

bind config_text_tokenizer_core ctt_checker u_ctt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_tok.valid),
    .out_ready  (out_tok.ready),
    .kind       (out_tok.kind),
    .start_pos  (out_tok.start_pos),
    .end_pos    (out_tok.end_pos),
    .error_code (out_tok.error_code),
    .last       (out_tok.last)
);
